/* sv/frt_pkg.sv */
// Package for the fragment reassembly tracker: constants, codes and the context type.
`timescale 1ns / 1ps
package frt_pkg;

	localparam int PLATFORMS        = 16;
	localparam int CHANNELS         = 256;
	localparam int FULL_FRAGMENT    = 65503;
	localparam int ELI_HEADER_BYTES = 24;

	localparam int PLAT_W = (PLATFORMS > 1) ? $clog2(PLATFORMS) : 1;
	localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CTX_W  = PLAT_W + CHAN_W;
	localparam int NCTX   = 1 << CTX_W;

	localparam int CNT_W  = 33;
	localparam int SIZE_W = 16;

	localparam logic [15:0] MARK_VALUE = 16'hEC0A;
	localparam logic [SIZE_W-1:0] HDR_SINGLE = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] HDR_MULTI  = SIZE_W'(4);

	typedef enum logic [1:0] {
		PART_BEGIN  = 2'd0,
		PART_MIDDLE = 2'd1,
		PART_END    = 2'd2,
		PART_SINGLE = 2'd3
	} part_t;

	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_BAD_MARK      = 4'd1,
		ERR_BEGIN_SHORT   = 4'd2,
		ERR_MIDDLE_SHORT  = 4'd3,
		ERR_MIDDLE_ORPHAN = 4'd4,
		ERR_END_ORPHAN    = 4'd5,
		ERR_SIZE_MISMATCH = 4'd6,
		ERR_SINGLE_BIG    = 4'd7,
		ERR_SINGLE_SIZE   = 4'd8,
		ERR_RUNT          = 4'd9
	} err_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic             pending;
		logic [CNT_W-1:0] byte_count;
		logic [CNT_W-1:0] expected_size;
	} ctx_t;

	localparam int CTX_BITS = $bits(ctx_t);

endpackage

/* sv/frt_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/fragment_reassembly_tracker.sv */
// Top level of the fragment reassembly tracker: context memory, sequencer and result register.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_ready, part .. declared_payload | in
//   result  | out_valid, out_ready, accept_content .. error_code | out
//   config  | cfg_write_en, cfg_write_data              | in
//
// An item takes two steps: its sender context is read from the context RAM as it is accepted,
// then it is evaluated, the context is written back and the result register is loaded.
// After reset a clearing pass zeroes all 4096 entries of the context RAM; in_ready is low meanwhile.
// A result that is not taken holds the block in its evaluate cycle until out_ready.
`timescale 1ns / 1ps
module fragment_reassembly_tracker
	import frt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  part,
	input  logic [3:0]  platform,
	input  logic [7:0]  channel,
	input  logic [15:0] received_size,
	input  logic [15:0] header_mark,
	input  logic [31:0] declared_payload,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accept_content,
	output logic [32:0] write_offset,
	output logic [15:0] content_bytes,
	output logic        complete,
	output logic [32:0] message_size,
	output logic        discarded_pending,
	output logic [3:0]  error_code
);

	localparam logic [CTX_W-1:0] CTX_LAST = CTX_W'(NCTX - 1);

	state_t state_q, state_next;
	logic [CTX_W-1:0] clr_cnt_q;
	logic mode_q;

	logic [1:0]  part_q;
	logic [CTX_W-1:0] ix_q;
	logic [15:0] rx_q;
	logic [15:0] mark_q;
	logic [31:0] declared_q;

	logic in_fire, proceed;
	logic [CTX_W-1:0] rd_ix;
	logic mem_we;
	logic [CTX_W-1:0] mem_waddr;
	ctx_t mem_wdata;
	logic [CTX_BITS-1:0] mem_rdata;
	ctx_t ctx_rd;

	logic [SIZE_W-1:0] hdr, content;
	logic runt;
	part_t part_eff;
	logic [CNT_W:0] sum_wide;
	logic [CNT_W-1:0] sum_sat;
	ctx_t ctx_new;
	logic ctx_we;
	logic acc_d, cmp_d, disc_d;
	logic [CNT_W-1:0] off_d, msize_d;
	err_t err_d;

	logic out_valid_q;
	logic acc_q, cmp_q, disc_q;
	logic [CNT_W-1:0] off_q, msize_q;
	logic [SIZE_W-1:0] content_q;
	err_t err_q;

	assign in_fire = in_valid && in_ready;
	assign proceed = (state_q == ST_CALC) && (!out_valid_q || out_ready);
	assign rd_ix   = {platform[PLAT_W-1:0], channel[CHAN_W-1:0]};
	assign ctx_rd  = ctx_t'(mem_rdata);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CTX_LAST) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_CALC;
				end
			end
			ST_CALC: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ix_q;
		mem_wdata = ctx_new;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CALC: begin
				mem_we = proceed && ctx_we;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			mode_q    <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_write_en) begin
				mode_q <= cfg_write_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			part_q     <= part;
			ix_q       <= rd_ix;
			rx_q       <= received_size;
			mark_q     <= header_mark;
			declared_q <= declared_payload;
		end
	end

	frt_ram #(
		.WIDTH(CTX_BITS),
		.DEPTH(NCTX)
	) u_ctx_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (in_fire),
		.raddr(rd_ix),
		.rdata(mem_rdata)
	);

	assign hdr      = mode_q ? HDR_SINGLE : HDR_MULTI;
	assign runt     = rx_q < hdr;
	assign content  = runt ? '0 : (rx_q - hdr);
	assign part_eff = mode_q ? PART_SINGLE : part_t'(part_q);
	assign sum_wide = {1'b0, ctx_rd.byte_count} + (CNT_W + 1)'(content);
	assign sum_sat  = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];

	always_comb begin
		ctx_new = ctx_rd;
		ctx_we  = 1'b0;
		acc_d   = 1'b0;
		cmp_d   = 1'b0;
		disc_d  = 1'b0;
		off_d   = '0;
		msize_d = '0;
		err_d   = ERR_NONE;
		if (runt) begin
			err_d = ERR_RUNT;
		end else begin
			case (part_eff)
				PART_BEGIN: begin
					ctx_we          = 1'b1;
					disc_d          = ctx_rd.pending;
					ctx_new.pending = 1'b0;
					if (mark_q != MARK_VALUE) begin
						err_d = ERR_BAD_MARK;
					end else if (content != SIZE_W'(FULL_FRAGMENT)) begin
						err_d = ERR_BEGIN_SHORT;
					end else begin
						ctx_new.pending       = 1'b1;
						ctx_new.byte_count    = CNT_W'(content);
						ctx_new.expected_size = {1'b0, declared_q}
							+ CNT_W'(ELI_HEADER_BYTES);
						acc_d = 1'b1;
					end
				end
				PART_MIDDLE: begin
					if (!ctx_rd.pending) begin
						err_d = ERR_MIDDLE_ORPHAN;
					end else if (content != SIZE_W'(FULL_FRAGMENT)) begin
						err_d = ERR_MIDDLE_SHORT;
					end else begin
						ctx_we             = 1'b1;
						acc_d              = 1'b1;
						off_d              = ctx_rd.byte_count;
						ctx_new.byte_count = sum_sat;
					end
				end
				PART_END: begin
					ctx_we             = 1'b1;
					ctx_new.pending    = 1'b0;
					ctx_new.byte_count = '0;
					if (!ctx_rd.pending) begin
						err_d = ERR_END_ORPHAN;
					end else begin
						acc_d = 1'b1;
						off_d = ctx_rd.byte_count;
						if (sum_sat == ctx_rd.expected_size) begin
							cmp_d   = 1'b1;
							msize_d = sum_sat;
						end else begin
							err_d = ERR_SIZE_MISMATCH;
						end
					end
				end
				default: begin
					ctx_we             = 1'b1;
					disc_d             = ctx_rd.pending;
					ctx_new.pending    = 1'b0;
					ctx_new.byte_count = '0;
					if (mark_q != MARK_VALUE) begin
						err_d = ERR_BAD_MARK;
					end else if (declared_q >= 32'(FULL_FRAGMENT)) begin
						err_d = ERR_SINGLE_BIG;
					end else if (content < SIZE_W'(ELI_HEADER_BYTES) ||
						declared_q != 32'(content - SIZE_W'(ELI_HEADER_BYTES))) begin
						err_d = ERR_SINGLE_SIZE;
					end else begin
						acc_d   = 1'b1;
						cmp_d   = 1'b1;
						msize_d = CNT_W'(content);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed) begin
			acc_q     <= acc_d;
			off_q     <= off_d;
			content_q <= content;
			cmp_q     <= cmp_d;
			msize_q   <= msize_d;
			disc_q    <= disc_d;
			err_q     <= err_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign accept_content    = acc_q;
	assign write_offset      = off_q;
	assign content_bytes     = content_q;
	assign complete          = cmp_q;
	assign message_size      = msize_q;
	assign discarded_pending = disc_q;
	assign error_code        = err_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("Item accepted during the clearing pass.");

	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CALC))
		else $error("Accepted item did not move to evaluation.");

	a_complete_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && complete) |-> (error_code == ERR_NONE && accept_content))
		else $error("Completed message reported with an error or without content.");

	a_runt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_RUNT) |-> (!discarded_pending && !accept_content))
		else $error("Short fragment reported a discard or accepted content.");

endmodule
